// ===== hw/rtl/etint_pkg.sv =====
`timescale 1ns / 1ps
package etint_pkg;

   localparam int DAY_W           = 24;
   localparam int POS_W           = 48;
   localparam int VEL_W           = 32;
   localparam int MAG_W           = 48;
   localparam int NUM_B_W         = 24;
   localparam int PROD_W          = 72;
   localparam int REM_W           = 25;
   localparam int ARITH_CNT_W     = 7;
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int NUM_POS         = 3;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam logic [9:0] SEC_SCALE = 10'd675;

   typedef struct packed {
      logic [1:0]                command;
      logic signed [DAY_W-1:0]   epoch_day;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
      logic signed [VEL_W-1:0]   vel_x;
      logic signed [VEL_W-1:0]   vel_y;
      logic signed [VEL_W-1:0]   vel_z;
   } req_word_type;

   typedef struct packed {
      logic                      found;
      logic                      estimated;
      logic signed [DAY_W-1:0]   out_day;
      logic signed [POS_W-1:0]   out_pos_x;
      logic signed [POS_W-1:0]   out_pos_y;
      logic signed [POS_W-1:0]   out_pos_z;
      logic signed [VEL_W-1:0]   out_vel_x;
      logic signed [VEL_W-1:0]   out_vel_y;
      logic signed [VEL_W-1:0]   out_vel_z;
   } rsp_word_type;

   typedef struct packed {
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
      logic signed [VEL_W-1:0]   vel_x;
      logic signed [VEL_W-1:0]   vel_y;
      logic signed [VEL_W-1:0]   vel_z;
   } rec_type;

   typedef struct packed {
      logic start;
      logic use_div;
   } arith_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_sts_type;

endpackage

// ===== hw/rtl/etint_store.sv =====
`timescale 1ns / 1ps
module etint_store #(
   parameter int TABLE_DEPTH = etint_pkg::TABLE_DEPTH_DEF,
   parameter int AW          = $clog2(TABLE_DEPTH)
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [AW-1:0]                       wr_addr,
   input  logic signed [etint_pkg::DAY_W-1:0]  wr_day,
   input  etint_pkg::rec_type                  wr_rec,
   input  logic [AW-1:0]                       rd_addr,
   output logic signed [etint_pkg::DAY_W-1:0]  day_rd,
   output etint_pkg::rec_type                  rec_rd
);

   logic [etint_pkg::DAY_W-1:0]         day_mem [TABLE_DEPTH];
   etint_pkg::rec_type                  rec_mem [TABLE_DEPTH];
   logic signed [etint_pkg::DAY_W-1:0]  day_rd_ff;
   etint_pkg::rec_type                  rec_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         day_mem[wr_addr] <= wr_day;
         rec_mem[wr_addr] <= wr_rec;
      end
      day_rd_ff <= day_mem[rd_addr];
      rec_rd_ff <= rec_mem[rd_addr];
   end

   assign day_rd = day_rd_ff;
   assign rec_rd = rec_rd_ff;

endmodule

// ===== hw/rtl/etint_arith.sv =====
`timescale 1ns / 1ps
module etint_arith (
   input  logic                              clock,
   input  logic                              reset,
   input  etint_pkg::arith_cmd_type          cmd,
   input  logic [etint_pkg::MAG_W-1:0]       mul_a,
   input  logic [etint_pkg::NUM_B_W-1:0]     mul_b,
   input  logic [etint_pkg::NUM_B_W-1:0]     div_den,
   output etint_pkg::arith_sts_type          sts,
   output logic [etint_pkg::PROD_W-1:0]      result
);

   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_MUL  = 2'd1;
   localparam logic [1:0] P_DIV  = 2'd2;

   logic [1:0]                            phase_ff;
   logic [etint_pkg::ARITH_CNT_W-1:0]     cnt_ff;
   logic [etint_pkg::PROD_W-1:0]          acc_ff;
   logic [etint_pkg::REM_W-1:0]           rem_ff;
   logic [etint_pkg::MAG_W-1:0]           a_ff;
   logic [etint_pkg::NUM_B_W-1:0]         b_ff;
   logic [etint_pkg::NUM_B_W-1:0]         den_ff;
   logic                                  div_ff;
   logic                                  done_ff;

   logic [etint_pkg::PROD_W-1:0]          acc_mul_in;
   logic [etint_pkg::REM_W-1:0]           rem_shift;
   logic                                  qbit;

   always_comb begin
      acc_mul_in = {acc_ff[etint_pkg::PROD_W-2:0], 1'b0}
                 + (b_ff[etint_pkg::NUM_B_W-1] ? etint_pkg::PROD_W'(a_ff)
                                              : etint_pkg::PROD_W'(0));
      rem_shift  = {rem_ff[etint_pkg::REM_W-2:0], acc_ff[etint_pkg::PROD_W-1]};
      qbit       = rem_shift >= etint_pkg::REM_W'(den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            P_IDLE: begin
               if (cmd.start) begin
                  a_ff     <= mul_a;
                  b_ff     <= mul_b;
                  den_ff   <= div_den;
                  div_ff   <= cmd.use_div;
                  acc_ff   <= '0;
                  cnt_ff   <= etint_pkg::ARITH_CNT_W'(etint_pkg::NUM_B_W - 1);
                  phase_ff <= P_MUL;
               end
            end
            P_MUL: begin
               acc_ff <= acc_mul_in;
               b_ff   <= {b_ff[etint_pkg::NUM_B_W-2:0], 1'b0};
               if (cnt_ff == '0) begin
                  if (div_ff) begin
                     rem_ff   <= '0;
                     cnt_ff   <= etint_pkg::ARITH_CNT_W'(etint_pkg::PROD_W - 1);
                     phase_ff <= P_DIV;
                  end else begin
                     done_ff  <= 1'b1;
                     phase_ff <= P_IDLE;
                  end
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            P_DIV: begin
               rem_ff <= qbit ? rem_shift - etint_pkg::REM_W'(den_ff) : rem_shift;
               acc_ff <= {acc_ff[etint_pkg::PROD_W-2:0], qbit};
               if (cnt_ff == '0) begin
                  done_ff  <= 1'b1;
                  phase_ff <= P_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: phase_ff <= P_IDLE;
         endcase
      end
   end

   assign sts.busy = phase_ff != P_IDLE;
   assign sts.done = done_ff;
   assign result   = acc_ff;

endmodule

// ===== hw/rtl/ephemeris_table_interpolator.sv =====
`timescale 1ns / 1ps
// Table of day-ordered state records with lookup, interpolation and extrapolation.
// Input channel req_valid / req_stall / req_word: command clear, load or query.
// Result channel rsp_valid / rsp_stall / rsp_word: one word per query only.
// Clear and load finish when accepted; a load into a full table is dropped.
// A query scans the day memory one entry a cycle, then reads one or two
// records. Exact matches finish there.
// Interpolation runs six components through one shift-add multiplier and
// restoring divider, one component after another.
// Extrapolation runs the three positions through the multiplier only.
// One query is worked at a time; the next word is taken once the result is
// in the output register, even while that register waits on rsp_stall.
// The output register holds its word for as long as rsp_stall is high.
// Reset empties the table and the output register; memory contents are kept.
module ephemeris_table_interpolator #(
   parameter int TABLE_DEPTH = etint_pkg::TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  etint_pkg::req_word_type  req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output etint_pkg::rsp_word_type  rsp_word
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int DW = etint_pkg::DAY_W;
   localparam int PW = etint_pkg::POS_W;
   localparam int VW = etint_pkg::VEL_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_RDA    = 3'd2;
   localparam logic [2:0] S_RDB    = 3'd3;
   localparam logic [2:0] S_RDC    = 3'd4;
   localparam logic [2:0] S_CSTART = 3'd5;
   localparam logic [2:0] S_CWAIT  = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   localparam logic [1:0] M_NONE   = 2'd0;
   localparam logic [1:0] M_EXACT  = 2'd1;
   localparam logic [1:0] M_LERP   = 2'd2;
   localparam logic [1:0] M_EXTRAP = 2'd3;

   localparam logic [2:0] LAST_LERP   = 3'd5;
   localparam logic [2:0] LAST_EXTRAP = 3'd2;
   localparam logic [2:0] FIRST_VEL   = 3'd3;

   localparam logic signed [51:0] POS_MAX = 52'sd140737488355327;
   localparam logic signed [51:0] POS_MIN = -52'sd140737488355328;

   logic [2:0]               state_ff;
   logic [1:0]               mode_ff;
   logic [CW-1:0]            cnt_ff;
   logic [CW-1:0]            scan_ff;
   logic                     pend_ff;
   logic [AW-1:0]            pidx_ff;
   logic signed [DW-1:0]     t_ff;
   logic                     exact_hit_ff;
   logic [AW-1:0]            exact_idx_ff;
   logic                     brk_hit_ff;
   logic [AW-1:0]            brk_idx_ff;
   logic signed [DW-1:0]     da_ff;
   logic signed [DW-1:0]     db_ff;
   logic signed [DW-1:0]     prev_ff;
   logic signed [DW-1:0]     first_ff;
   logic signed [DW-1:0]     last_ff;
   logic [AW-1:0]            ent_ff;
   logic signed [DW-1:0]     ext_day_ff;
   etint_pkg::rec_type       rec_a_ff;
   etint_pkg::rec_type       rec_b_ff;
   logic [2:0]               comp_ff;
   logic                     neg_ff;
   logic signed [49:0]       keep_ff;
   logic signed [PW-1:0]     res_pos_ff [etint_pkg::NUM_POS];
   logic signed [VW-1:0]     res_vel_ff [etint_pkg::NUM_POS];
   logic                     found_ff;
   logic                     est_ff;
   etint_pkg::rsp_word_type  rsp_ff;
   logic                     rsp_valid_ff;

   logic                     req_acc;
   logic                     st_wr_en;
   logic [AW-1:0]            st_rd_addr;
   etint_pkg::rec_type       st_wr_rec;
   logic signed [DW-1:0]     day_rd;
   etint_pkg::rec_type       rec_rd;

   etint_pkg::arith_cmd_type ar_cmd;
   etint_pkg::arith_sts_type ar_sts;
   logic [etint_pkg::MAG_W-1:0]   ar_a;
   logic [etint_pkg::NUM_B_W-1:0] ar_b;
   logic [etint_pkg::NUM_B_W-1:0] ar_den;
   logic [etint_pkg::PROD_W-1:0]  ar_res;

   logic signed [49:0]       op_a;
   logic signed [49:0]       op_b;
   logic signed [VW-1:0]     op_v;
   logic signed [49:0]       diff;
   logic [etint_pkg::MAG_W-1:0] lerp_mag;
   logic signed [DW:0]       num_w;
   logic signed [DW:0]       den_w;
   logic signed [32:0]       vext;
   logic [32:0]              vabs;
   logic [42:0]              um;
   logic signed [DW:0]       delta;
   logic [DW:0]              dabs;
   logic                     start_neg;
   logic signed [49:0]       lerp_val;
   logic                     over;
   logic signed [51:0]       ext_sum;
   logic signed [PW-1:0]     ext_val;
   logic [1:0]               pidx2;
   logic [1:0]               vidx2;
   logic                     is_lerp;

   assign req_stall = state_ff != S_IDLE;
   assign req_acc   = req_valid && !req_stall;
   assign is_lerp   = mode_ff == M_LERP;

   assign st_wr_en  = req_acc && req_word.command == etint_pkg::CMD_LOAD
                      && cnt_ff < CW'(TABLE_DEPTH);
   assign st_wr_rec = '{pos_x: req_word.pos_x, pos_y: req_word.pos_y,
                        pos_z: req_word.pos_z, vel_x: req_word.vel_x,
                        vel_y: req_word.vel_y, vel_z: req_word.vel_z};

   always_comb begin
      case (state_ff)
         S_SCAN:  st_rd_addr = scan_ff[AW-1:0];
         S_RDB:   st_rd_addr = ent_ff + 1'b1;
         default: st_rd_addr = ent_ff;
      endcase
   end

   etint_store #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_day  (req_word.epoch_day),
      .wr_rec  (st_wr_rec),
      .rd_addr (st_rd_addr),
      .day_rd  (day_rd),
      .rec_rd  (rec_rd)
   );

   always_comb begin
      case (comp_ff)
         3'd0: begin
            op_a = 50'(rec_a_ff.pos_x);
            op_b = 50'(rec_b_ff.pos_x);
         end
         3'd1: begin
            op_a = 50'(rec_a_ff.pos_y);
            op_b = 50'(rec_b_ff.pos_y);
         end
         3'd2: begin
            op_a = 50'(rec_a_ff.pos_z);
            op_b = 50'(rec_b_ff.pos_z);
         end
         3'd3: begin
            op_a = 50'(rec_a_ff.vel_x);
            op_b = 50'(rec_b_ff.vel_x);
         end
         3'd4: begin
            op_a = 50'(rec_a_ff.vel_y);
            op_b = 50'(rec_b_ff.vel_y);
         end
         default: begin
            op_a = 50'(rec_a_ff.vel_z);
            op_b = 50'(rec_b_ff.vel_z);
         end
      endcase
      case (comp_ff)
         3'd0:    op_v = rec_a_ff.vel_x;
         3'd1:    op_v = rec_a_ff.vel_y;
         default: op_v = rec_a_ff.vel_z;
      endcase

      diff     = op_b - op_a;
      lerp_mag = diff[49] ? 48'(-diff) : 48'(diff);
      num_w    = (DW+1)'(t_ff) - (DW+1)'(da_ff);
      den_w    = (DW+1)'(db_ff) - (DW+1)'(da_ff);

      vext     = 33'(op_v);
      vabs     = vext[32] ? 33'(-vext) : 33'(vext);
      um       = 43'(vabs) * 43'(etint_pkg::SEC_SCALE);
      delta    = (DW+1)'(t_ff) - (DW+1)'(ext_day_ff);
      dabs     = delta[DW] ? (DW+1)'(-delta) : (DW+1)'(delta);

      start_neg = is_lerp ? diff[49] : (op_v[VW-1] ^ delta[DW]);
      ar_a      = is_lerp ? lerp_mag : etint_pkg::MAG_W'(um);
      ar_b      = is_lerp ? num_w[DW-1:0] : dabs[DW-1:0];
      ar_den    = den_w[DW-1:0];
      ar_cmd.start   = state_ff == S_CSTART;
      ar_cmd.use_div = is_lerp;

      lerp_val = neg_ff ? keep_ff - $signed({2'b00, ar_res[47:0]})
                        : keep_ff + $signed({2'b00, ar_res[47:0]});
      over     = (|ar_res[71:51]) || (ar_res[50] && (|ar_res[49:0]));
      ext_sum  = neg_ff ? 52'(keep_ff) - $signed({2'b00, ar_res[50:1]})
                        : 52'(keep_ff) + $signed({2'b00, ar_res[50:1]});
      if (over) begin
         ext_val = neg_ff ? PW'(POS_MIN) : PW'(POS_MAX);
      end else if (ext_sum > POS_MAX) begin
         ext_val = PW'(POS_MAX);
      end else if (ext_sum < POS_MIN) begin
         ext_val = PW'(POS_MIN);
      end else begin
         ext_val = PW'(ext_sum);
      end

      pidx2 = comp_ff[1:0];
      vidx2 = 2'(comp_ff - FIRST_VEL);
   end

   etint_arith u_arith (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ar_cmd),
      .mul_a   (ar_a),
      .mul_b   (ar_b),
      .div_den (ar_den),
      .sts     (ar_sts),
      .result  (ar_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  case (req_word.command)
                     etint_pkg::CMD_CLEAR: cnt_ff <= '0;
                     etint_pkg::CMD_LOAD: begin
                        if (st_wr_en) begin
                           cnt_ff <= cnt_ff + 1'b1;
                        end
                     end
                     etint_pkg::CMD_QUERY: begin
                        t_ff         <= req_word.epoch_day;
                        exact_hit_ff <= 1'b0;
                        brk_hit_ff   <= 1'b0;
                        scan_ff      <= '0;
                        pend_ff      <= 1'b0;
                        found_ff     <= 1'b0;
                        est_ff       <= 1'b0;
                        for (int k = 0; k < etint_pkg::NUM_POS; k++) begin
                           res_pos_ff[k] <= '0;
                           res_vel_ff[k] <= '0;
                        end
                        mode_ff  <= M_NONE;
                        state_ff <= (cnt_ff == '0) ? S_OUT : S_SCAN;
                     end
                     default: ;
                  endcase
               end
            end
            S_SCAN: begin
               if (scan_ff < cnt_ff) begin
                  scan_ff <= scan_ff + 1'b1;
                  pidx_ff <= scan_ff[AW-1:0];
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff) begin
                  if (day_rd == t_ff && !exact_hit_ff) begin
                     exact_hit_ff <= 1'b1;
                     exact_idx_ff <= pidx_ff;
                  end
                  if (pidx_ff != '0 && prev_ff < t_ff && t_ff < day_rd && !brk_hit_ff) begin
                     brk_hit_ff <= 1'b1;
                     brk_idx_ff <= pidx_ff - 1'b1;
                     da_ff      <= prev_ff;
                     db_ff      <= day_rd;
                  end
                  if (pidx_ff == '0) begin
                     first_ff <= day_rd;
                  end
                  last_ff <= day_rd;
                  prev_ff <= day_rd;
               end else if (scan_ff == cnt_ff) begin
                  if (exact_hit_ff) begin
                     mode_ff  <= M_EXACT;
                     ent_ff   <= exact_idx_ff;
                     state_ff <= S_RDA;
                  end else if (brk_hit_ff) begin
                     mode_ff  <= M_LERP;
                     ent_ff   <= brk_idx_ff;
                     state_ff <= S_RDA;
                  end else if (t_ff < first_ff) begin
                     mode_ff    <= M_EXTRAP;
                     ent_ff     <= '0;
                     ext_day_ff <= first_ff;
                     state_ff   <= S_RDA;
                  end else if (t_ff > last_ff) begin
                     mode_ff    <= M_EXTRAP;
                     ent_ff     <= AW'(cnt_ff - 1'b1);
                     ext_day_ff <= last_ff;
                     state_ff   <= S_RDA;
                  end else begin
                     mode_ff  <= M_NONE;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_RDA: state_ff <= S_RDB;
            S_RDB: begin
               rec_a_ff <= rec_rd;
               state_ff <= S_RDC;
            end
            S_RDC: begin
               rec_b_ff      <= rec_rd;
               res_pos_ff[0] <= rec_a_ff.pos_x;
               res_pos_ff[1] <= rec_a_ff.pos_y;
               res_pos_ff[2] <= rec_a_ff.pos_z;
               res_vel_ff[0] <= rec_a_ff.vel_x;
               res_vel_ff[1] <= rec_a_ff.vel_y;
               res_vel_ff[2] <= rec_a_ff.vel_z;
               found_ff      <= 1'b1;
               est_ff        <= mode_ff == M_EXTRAP;
               comp_ff       <= '0;
               state_ff      <= (mode_ff == M_EXACT) ? S_OUT : S_CSTART;
            end
            S_CSTART: begin
               neg_ff   <= start_neg;
               keep_ff  <= op_a;
               state_ff <= S_CWAIT;
            end
            S_CWAIT: begin
               if (ar_sts.done) begin
                  if (comp_ff < FIRST_VEL) begin
                     res_pos_ff[pidx2] <= is_lerp ? PW'(lerp_val) : ext_val;
                  end else begin
                     res_vel_ff[vidx2] <= VW'(lerp_val);
                  end
                  if (comp_ff == (is_lerp ? LAST_LERP : LAST_EXTRAP)) begin
                     state_ff <= S_OUT;
                  end else begin
                     comp_ff  <= comp_ff + 1'b1;
                     state_ff <= S_CSTART;
                  end
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff <= '{found: found_ff, estimated: est_ff, out_day: t_ff,
                     out_pos_x: res_pos_ff[0], out_pos_y: res_pos_ff[1],
                     out_pos_z: res_pos_ff[2], out_vel_x: res_vel_ff[0],
                     out_vel_y: res_vel_ff[1], out_vel_z: res_vel_ff[2]};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_arith_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CSTART |-> !ar_sts.busy)
      else $error("arith start while busy");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result word raised outside output state");

   a_calc_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CSTART |-> (mode_ff == M_LERP || mode_ff == M_EXTRAP))
      else $error("calc started without a computing mode");

endmodule
